// ----- hw/rtl/asn1te_pkg.sv -----
// Shared types and constants for the ASN.1 time string to epoch seconds converter.
// Holds the item structs, parser phase codes, error codes and the month table.
// No dependencies.
package asn1te_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_generalized;
		logic       first_char;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic signed [38:0] epoch_seconds;
		logic [1:0]         error_code;
	} out_item_t;

	// Parser phases; the controller uses the codes above PH_DONE for its conversion steps.
	localparam logic [3:0] PH_YEAR   = 4'd0;
	localparam logic [3:0] PH_MON    = 4'd1;
	localparam logic [3:0] PH_DAY    = 4'd2;
	localparam logic [3:0] PH_HOUR   = 4'd3;
	localparam logic [3:0] PH_MIN    = 4'd4;
	localparam logic [3:0] PH_SECOPT = 4'd5;
	localparam logic [3:0] PH_SEC    = 4'd6;
	localparam logic [3:0] PH_FRAC   = 4'd7;
	localparam logic [3:0] PH_ZONE   = 4'd8;
	localparam logic [3:0] PH_OFFH   = 4'd9;
	localparam logic [3:0] PH_OFFM   = 4'd10;
	localparam logic [3:0] PH_DONE   = 4'd11;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_FORMAT = 2'd1;
	localparam logic [1:0] ERR_RANGE  = 2'd2;
	localparam logic [1:0] ERR_LOCAL  = 2'd3;

	typedef struct packed {
		logic       restart;     // first character: treat all fields as zero
		logic       clear;       // end of string: zero all fields
		logic       digit;       // fold the current digit into the field
		logic       store;       // the current digit completes the field
		logic [3:0] phase;
		logic [1:0] idx;         // digit position inside the field
		logic       generalized;
		logic       set_sign;
		logic       sign_neg;
		logic       ld_s1;
		logic       ld_s2;
		logic       ld_s3;
		logic       out_load;
		logic       out_conv;    // take the converted seconds, else a bare error code
		logic [1:0] out_code;
	} asn_cmd_t;

	typedef struct packed {
		logic is_digit;
		logic is_zulu;
		logic is_plus;
		logic is_minus;
		logic is_frac_mark;
		logic range_ok;
	} asn_sts_t;

	// Days in the year before the first day of the given month.
	function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] month);
		logic [8:0] base;
		unique case (month)
			4'd0, 4'd1: base = 9'd0;
			4'd2:       base = 9'd31;
			4'd3:       base = 9'd59;
			4'd4:       base = 9'd90;
			4'd5:       base = 9'd120;
			4'd6:       base = 9'd151;
			4'd7:       base = 9'd181;
			4'd8:       base = 9'd212;
			4'd9:       base = 9'd243;
			4'd10:      base = 9'd273;
			4'd11:      base = 9'd304;
			4'd12:      base = 9'd334;
			default:    base = 9'd365;
		endcase
		if (leap && (month > 4'd2)) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

// ----- hw/rtl/asn1te_ctl.sv -----
// Controller for the ASN.1 time converter: character parser state and conversion sequencer.
// Drives the datapath through asn_cmd_t and reads character class and range status back.
// Depends on asn1te_pkg.
module asn1te_ctl
	import asn1te_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     char_valid,
	input  logic     first_char,
	input  logic     last_char,
	input  logic     is_generalized,
	input  logic     result_stall,
	input  asn_sts_t sts,
	output logic     char_stall,
	output logic     result_valid,
	output asn_cmd_t cmd
);

	localparam logic [3:0] ST_CV1 = 4'd12;
	localparam logic [3:0] ST_CV2 = 4'd13;
	localparam logic [3:0] ST_CV3 = 4'd14;
	localparam logic [3:0] ST_CV4 = 4'd15;

	logic [3:0] state_q, state_n, ph, ph_n, zone_ph, field_next;
	logic [1:0] dc_q, dc_n, dc, last_idx;
	logic       err_q, err_n, err, gen_q, gen, out_valid_q;
	logic       out_free, busy, accept, zone_err, zone_sign, frac_skip;

	assign busy       = (state_q == ST_CV1) || (state_q == ST_CV2) ||
	                    (state_q == ST_CV3) || (state_q == ST_CV4);
	assign out_free   = !out_valid_q || !result_stall;
	assign char_stall = busy || !out_free;
	assign accept     = char_valid && !char_stall;
	assign result_valid = out_valid_q;

	// A first mark restarts the parse in the same cycle as its character.
	assign ph        = first_char ? PH_YEAR : state_q;
	assign dc        = first_char ? 2'd0 : dc_q;
	assign err       = first_char ? 1'b0 : err_q;
	assign gen       = first_char ? is_generalized : gen_q;
	assign last_idx  = ((ph == PH_YEAR) && gen) ? 2'd3 : 2'd1;
	assign frac_skip = sts.is_digit || sts.is_frac_mark;

	always_comb begin
		zone_ph   = ph;
		zone_err  = 1'b0;
		zone_sign = 1'b0;
		if (sts.is_zulu) begin
			zone_ph = PH_DONE;
		end else if (sts.is_plus || sts.is_minus) begin
			zone_ph   = PH_OFFH;
			zone_sign = 1'b1;
		end else begin
			zone_err = 1'b1;
		end
	end

	always_comb begin
		unique case (ph)
			PH_YEAR: field_next = PH_MON;
			PH_MON:  field_next = PH_DAY;
			PH_DAY:  field_next = PH_HOUR;
			PH_HOUR: field_next = PH_MIN;
			PH_MIN:  field_next = PH_SECOPT;
			PH_SEC:  field_next = gen ? PH_FRAC : PH_ZONE;
			PH_OFFH: field_next = PH_OFFM;
			default: field_next = PH_DONE;
		endcase
	end

	always_comb begin
		ph_n    = ph;
		dc_n    = dc;
		err_n   = err;
		state_n = state_q;
		cmd             = '0;
		cmd.phase       = ph;
		cmd.idx         = dc;
		cmd.generalized = gen;
		cmd.sign_neg    = sts.is_minus;
		if (busy) begin
			unique case (state_q)
				ST_CV1: begin
					cmd.ld_s1 = 1'b1;
					state_n   = ST_CV2;
				end
				ST_CV2: begin
					cmd.ld_s2 = 1'b1;
					state_n   = ST_CV3;
				end
				ST_CV3: begin
					cmd.ld_s3 = 1'b1;
					state_n   = ST_CV4;
				end
				default: begin
					if (out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_conv = 1'b1;
						cmd.clear    = 1'b1;
						state_n      = PH_YEAR;
					end
				end
			endcase
		end else if (accept) begin
			cmd.restart = first_char;
			if (!err) begin
				unique case (ph) inside
					PH_YEAR, PH_MON, PH_DAY, PH_HOUR, PH_MIN, PH_SEC, PH_OFFH, PH_OFFM: begin
						if (!sts.is_digit) begin
							err_n = 1'b1;
						end else begin
							cmd.digit = 1'b1;
							if (dc == last_idx) begin
								cmd.store = 1'b1;
								dc_n      = 2'd0;
								ph_n      = field_next;
								if (!sts.range_ok) begin
									err_n = 1'b1;
								end
							end else begin
								dc_n = dc + 2'd1;
							end
						end
					end
					PH_SECOPT: begin
						if (sts.is_digit) begin
							cmd.digit = 1'b1;
							dc_n      = 2'd1;
							ph_n      = PH_SEC;
						end else if (!(gen && frac_skip)) begin
							ph_n         = zone_ph;
							err_n        = zone_err;
							cmd.set_sign = zone_sign;
						end
					end
					PH_FRAC: begin
						if (!frac_skip) begin
							ph_n         = zone_ph;
							err_n        = zone_err;
							cmd.set_sign = zone_sign;
						end
					end
					PH_ZONE: begin
						ph_n         = zone_ph;
						err_n        = zone_err;
						cmd.set_sign = zone_sign;
					end
					default: begin
						err_n = 1'b1;
					end
				endcase
			end
			state_n = ph_n;
			if (last_char) begin
				if (!err_n && (ph_n == PH_DONE)) begin
					state_n = ST_CV1;
				end else begin
					cmd.out_load = 1'b1;
					cmd.clear    = 1'b1;
					state_n      = PH_YEAR;
					if (!err_n && ((ph_n == PH_SECOPT) || (ph_n == PH_FRAC)) && gen) begin
						cmd.out_code = ERR_LOCAL;
					end else begin
						cmd.out_code = ERR_FORMAT;
					end
				end
				dc_n  = 2'd0;
				err_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= PH_YEAR;
			dc_q        <= 2'd0;
			err_q       <= 1'b0;
			gen_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (accept && !busy) begin
				dc_q  <= dc_n;
				err_q <= err_n;
				gen_q <= gen;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hw/rtl/asn1te_dp.sv -----
// Datapath for the ASN.1 time converter: character classes, field registers,
// the four-step seconds conversion and the result register.
// Depends on asn1te_pkg.
module asn1te_dp
	import asn1te_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic [7:0] char_code,
	input  asn_cmd_t  cmd,
	output asn_sts_t  sts,
	output out_item_t result_item
);

	logic [6:0] acc_q, cent_q, yy_q;
	logic [3:0] month_q, offh_q;
	logic [4:0] day_q, hour_q;
	logic [5:0] min_q, sec_q, offm_q;
	logic       neg_q;

	logic [3:0]  dig;
	logic [6:0]  acc_base, v;
	logic [10:0] v_full, yy_full;
	logic        range_ok;

	// Conversion step one
	logic [13:0]        year_c, year_s1;
	logic               ge_c, ge_s1, leap_c;
	logic [8:0]         dpart_c, dpart_s1;
	logic [16:0]        pos_c;
	logic [15:0]        offs_c;
	logic signed [18:0] tod_c, tod_s1;
	logic [6:0]         kmax_c, kmin_c, cnt_hi_c, cnt_lo_c;
	logic signed [7:0]  corr_c, corr_s1;
	// Conversion steps two to four
	logic [13:0]        q4_num;
	logic signed [24:0] yoff, q4s, days_c, days_s2;
	logic signed [41:0] prod_c, prod_s3, r_c;
	logic               ovf;
	out_item_t          out_q;

	assign dig = char_code[3:0];
	assign sts.is_digit     = (char_code >= 8'd48) && (char_code <= 8'd57);
	assign sts.is_zulu      = (char_code == 8'd90);
	assign sts.is_plus      = (char_code == 8'd43);
	assign sts.is_minus     = (char_code == 8'd45);
	assign sts.is_frac_mark = (char_code == 8'd46) || (char_code == 8'd44);
	assign sts.range_ok     = range_ok;

	assign acc_base = cmd.restart ? 7'd0 : acc_q;
	assign v_full   = {4'b0, acc_base} * 11'd10 + {7'b0, dig};
	assign v        = v_full[6:0];
	assign yy_full  = {4'b0, yy_q} * 11'd10 + {7'b0, dig};

	always_comb begin
		unique case (cmd.phase)
			PH_MON:           range_ok = (v >= 7'd1) && (v <= 7'd12);
			PH_DAY:           range_ok = (v >= 7'd1) && (v <= 7'd31);
			PH_HOUR:          range_ok = (v <= 7'd23);
			PH_MIN, PH_SEC, PH_OFFM: range_ok = (v <= 7'd59);
			PH_OFFH:          range_ok = (v <= 7'd12);
			default:          range_ok = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			cent_q  <= '0;
			yy_q    <= '0;
			month_q <= '0;
			day_q   <= '0;
			hour_q  <= '0;
			min_q   <= '0;
			sec_q   <= '0;
			offh_q  <= '0;
			offm_q  <= '0;
			neg_q   <= 1'b0;
		end else if (cmd.clear) begin
			acc_q   <= '0;
			cent_q  <= '0;
			yy_q    <= '0;
			month_q <= '0;
			day_q   <= '0;
			hour_q  <= '0;
			min_q   <= '0;
			sec_q   <= '0;
			offh_q  <= '0;
			offm_q  <= '0;
			neg_q   <= 1'b0;
		end else begin
			// The first character of a string is always a lone year digit, so
			// nothing but the accumulator is written alongside a restart.
			if (cmd.restart) begin
				cent_q  <= '0;
				yy_q    <= '0;
				month_q <= '0;
				day_q   <= '0;
				hour_q  <= '0;
				min_q   <= '0;
				sec_q   <= '0;
				offh_q  <= '0;
				offm_q  <= '0;
				neg_q   <= 1'b0;
			end
			if (cmd.digit) begin
				acc_q <= cmd.store ? 7'd0 : v;
			end else if (cmd.restart) begin
				acc_q <= '0;
			end
			// A four-digit year keeps its century and its year of century apart.
			if (cmd.digit && (cmd.phase == PH_YEAR) && cmd.generalized) begin
				if (cmd.idx == 2'd1) begin
					cent_q <= v;
				end else if (cmd.idx == 2'd2) begin
					yy_q <= {3'b0, dig};
				end else if (cmd.idx == 2'd3) begin
					yy_q <= yy_full[6:0];
				end
			end
			if (cmd.store) begin
				case (cmd.phase)
					PH_YEAR: begin
						if (!cmd.generalized) begin
							cent_q <= (v < 7'd50) ? 7'd20 : 7'd19;
							yy_q   <= v;
						end
					end
					PH_MON:  month_q <= v[3:0];
					PH_DAY:  day_q   <= v[4:0];
					PH_HOUR: hour_q  <= v[4:0];
					PH_MIN:  min_q   <= v[5:0];
					PH_SEC:  sec_q   <= v[5:0];
					PH_OFFH: offh_q  <= v[3:0];
					PH_OFFM: offm_q  <= v[5:0];
					default: ;
				endcase
			end
			if (cmd.set_sign) begin
				neg_q <= cmd.sign_neg;
			end
		end
	end

	// Step one: year, time of day with the zone offset, day of year, century correction.
	assign year_c  = {7'b0, cent_q} * 14'd100 + {7'b0, yy_q};
	assign ge_c    = (cent_q > 7'd19) || ((cent_q == 7'd19) && (yy_q >= 7'd70));
	assign leap_c  = (yy_q[1:0] == 2'd0) && ((yy_q != 7'd0) || (cent_q[1:0] == 2'd0));
	assign dpart_c = {4'b0, day_q} - 9'd1 + cum_days(leap_c, month_q);
	assign pos_c   = {11'b0, sec_q} + {11'b0, min_q} * 17'd60 + {12'b0, hour_q} * 17'd3600;
	assign offs_c  = {12'b0, offh_q} * 16'd3600 + {10'b0, offm_q} * 16'd60;
	assign tod_c   = neg_q ? ($signed({2'b0, pos_c}) + $signed({3'b0, offs_c}))
	                       : ($signed({2'b0, pos_c}) - $signed({3'b0, offs_c}));

	// Non-leap century years from 2100 up to before the year, or from the year up to 1900.
	assign kmax_c   = (yy_q == 7'd0) ? (cent_q - 7'd1) : cent_q;
	assign cnt_hi_c = (kmax_c > 7'd20) ? (kmax_c - 7'd15 - (kmax_c >> 2)) : 7'd0;
	assign kmin_c   = (yy_q == 7'd0) ? cent_q : (cent_q + 7'd1);
	assign cnt_lo_c = 7'd15 - kmin_c + ((kmin_c + 7'd3) >> 2);
	assign corr_c   = ge_c ? -$signed({1'b0, cnt_hi_c}) : $signed({1'b0, cnt_lo_c});

	// Step two: whole days since 1970.
	assign q4_num = ge_s1 ? (year_s1 - 14'd1969) : (14'd1972 - year_s1);
	assign q4s    = $signed({13'b0, q4_num[13:2]});
	assign yoff   = $signed({11'b0, year_s1}) - 25'sd1970;
	assign days_c = yoff * 25'sd365 + (ge_s1 ? q4s : -q4s)
	                + $signed({{17{corr_s1[7]}}, corr_s1}) + $signed({16'b0, dpart_s1});

	// Step three: days to seconds. Step four: add time of day, check the sign.
	assign prod_c = $signed({{17{days_s2[24]}}, days_s2}) * 42'sd86400;
	assign r_c    = prod_s3 + $signed({{23{tod_s1[18]}}, tod_s1});
	assign ovf    = ge_s1 ? r_c[41] : !r_c[41];

	always_ff @(posedge clk) begin
		if (cmd.ld_s1) begin
			year_s1  <= year_c;
			ge_s1    <= ge_c;
			dpart_s1 <= dpart_c;
			tod_s1   <= tod_c;
			corr_s1  <= corr_c;
		end
		if (cmd.ld_s2) begin
			days_s2 <= days_c;
		end
		if (cmd.ld_s3) begin
			prod_s3 <= prod_c;
		end
		if (cmd.out_load) begin
			if (cmd.out_conv) begin
				out_q.epoch_seconds <= ovf ? 39'sd0 : r_c[38:0];
				out_q.error_code    <= ovf ? ERR_RANGE : ERR_NONE;
			end else begin
				out_q.epoch_seconds <= 39'sd0;
				out_q.error_code    <= cmd.out_code;
			end
		end
	end

	assign result_item = out_q;

endmodule

// ----- hw/rtl/asn1_time_to_epoch_seconds_top.sv -----
// Top level of the ASN.1 UTCTime / GeneralizedTime to epoch seconds converter.
// Joins the controller and the datapath; depends on asn1te_pkg, asn1te_ctl, asn1te_dp.
//
//   channel   dir   handshake                   payload
//   char      in    char_valid / char_stall     char_item   (in_item_t)
//   result    out   result_valid / result_stall result_item (out_item_t)
//
// Each character is parsed in the cycle that takes it. A last character that closes a
// string with a zone designator and no earlier error starts a conversion sequence (year
// and time of day, day count, day-to-seconds multiply, final add); char_stall is high
// during it. Other strings load their result at the edge that takes the last character,
// so it shows in the cycle after. While a result waits under result_stall, char_stall
// stays high. Reset clears all parse state and the result valid.
module asn1_time_to_epoch_seconds_top
	import asn1te_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_stall,
	input  in_item_t  char_item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result_item
);

	asn_cmd_t cmd;
	asn_sts_t sts;

	asn1te_ctl u_ctl (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_valid     (char_valid),
		.first_char     (char_item.first_char),
		.last_char      (char_item.last_char),
		.is_generalized (char_item.is_generalized),
		.result_stall   (result_stall),
		.sts            (sts),
		.char_stall     (char_stall),
		.result_valid   (result_valid),
		.cmd            (cmd)
	);

	asn1te_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_code   (char_item.char_code),
		.cmd         (cmd),
		.sts         (sts),
		.result_item (result_item)
	);

endmodule
